// ===== rtl/core/bdq_pkg.sv =====
// ----------------------------------------------------------------------------
// bdq_pkg
// Shared types and constants for the bounded deque: request codes, result
// kinds, datapath operations and the controller/datapath interface structs.
// ----------------------------------------------------------------------------
package bdq_pkg;

   localparam int CAPACITY_DEF = 64;
   localparam int VALUE_W      = 32;
   localparam int CODE_W       = 3;

   typedef enum logic [CODE_W-1:0] {
      REQ_CREATE     = 3'd0,
      REQ_PUSH_BACK  = 3'd1,
      REQ_PUSH_FRONT = 3'd2,
      REQ_POP_BACK   = 3'd3,
      REQ_LIST_ALL   = 3'd4,
      REQ_REVERSE    = 3'd5
   } req_code_type;

   typedef enum logic [CODE_W-1:0] {
      KIND_DONE        = 3'd0,
      KIND_ELEM        = 3'd1,
      KIND_NOT_CREATED = 3'd2,
      KIND_FULL        = 3'd3,
      KIND_EMPTY       = 3'd4
   } kind_type;

   typedef enum logic [2:0] {
      OP_NONE,
      OP_CLEAR,
      OP_PUSH_HIGH,
      OP_PUSH_LOW,
      OP_POP,
      OP_REVERSE,
      OP_LIST_START,
      OP_LIST_READ
   } dp_op_type;

   typedef struct packed {
      dp_op_type op;
      logic      status_load;
      kind_type  status_kind;
   } ctrl_cmd_type;

   typedef struct packed {
      logic created;
      logic empty;
      logic full;
      logic reversed;
      logic list_more;
      logic rsp_free;
   } dp_status_type;

endpackage

// ===== rtl/core/bounded_deque_with_reverse.sv =====
// ----------------------------------------------------------------------------
// bounded_deque_with_reverse
// Bounded deque of signed 32-bit values in a ring RAM with push, pop,
// reverse (direction flag) and list-all requests.
// ----------------------------------------------------------------------------
// status: a status result is valid in the cycle after its request is accepted
// list: acceptance loads the read pointer, then each element is read through
//    the single registered RAM read port, 1 element per cycle while rsp_ready is high
// throughput: 1 request per cycle for non-list requests when rsp_ready is high
// reset: synchronous; list becomes not created, RAM contents are kept
// ----------------------------------------------------------------------------
module bounded_deque_with_reverse
   import bdq_pkg::*;
#(
   parameter int CAPACITY = CAPACITY_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [CODE_W-1:0]         req_type,
   input  logic signed [VALUE_W-1:0] req_item_value,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic signed [VALUE_W-1:0] rsp_out_value,
   output logic [CODE_W-1:0]         rsp_result_kind,
   output logic                      rsp_last_of_run
);

   ctrl_cmd_type  cmd;
   dp_status_type status;

   bdq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_type  (req_type),
      .status    (status),
      .cmd       (cmd)
   );

   bdq_dp #(
      .CAPACITY (CAPACITY)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .item_value      (req_item_value),
      .status          (status),
      .rsp_ready       (rsp_ready),
      .rsp_valid       (rsp_valid),
      .rsp_out_value   (rsp_out_value),
      .rsp_result_kind (rsp_result_kind),
      .rsp_last_of_run (rsp_last_of_run)
   );

endmodule

// ===== rtl/core/bdq_ram.sv =====
// ----------------------------------------------------------------------------
// bdq_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bdq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/bdq_ctrl.sv =====
// ----------------------------------------------------------------------------
// bdq_ctrl
// Request decoder and sequencer: decides the status result and datapath
// operation for each request and steps the list read-out.
// ----------------------------------------------------------------------------
module bdq_ctrl
   import bdq_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [CODE_W-1:0] req_type,
   input  dp_status_type     status,
   output ctrl_cmd_type      cmd
);

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_LIST = 2'b10
   } state_type;

   state_type    state_ff, state_in;
   logic         accept;
   req_code_type code;

   assign req_ready = (state_ff == ST_IDLE) && status.rsp_free;
   assign accept    = req_valid && req_ready;
   assign code      = req_code_type'(req_type);

   always_comb begin
      cmd.op          = OP_NONE;
      cmd.status_load = 1'b0;
      cmd.status_kind = KIND_DONE;
      state_in        = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cmd.status_load = 1'b1;
               if (code == REQ_CREATE) begin
                  cmd.op = OP_CLEAR;
               end else if ((code inside {[REQ_PUSH_BACK:REQ_REVERSE]}) &&
                            !status.created) begin
                  cmd.status_kind = KIND_NOT_CREATED;
               end else begin
                  case (code)
                     REQ_PUSH_BACK, REQ_PUSH_FRONT: begin
                        if (status.full) begin
                           cmd.status_kind = KIND_FULL;
                        end else if ((code == REQ_PUSH_BACK) != status.reversed) begin
                           cmd.op = OP_PUSH_HIGH;
                        end else begin
                           cmd.op = OP_PUSH_LOW;
                        end
                     end
                     REQ_POP_BACK: begin
                        if (status.empty) begin
                           cmd.status_kind = KIND_EMPTY;
                        end else begin
                           cmd.op = OP_POP;
                        end
                     end
                     REQ_LIST_ALL: begin
                        if (status.empty) begin
                           cmd.status_kind = KIND_EMPTY;
                        end else begin
                           cmd.op          = OP_LIST_START;
                           cmd.status_load = 1'b0;
                           state_in        = ST_LIST;
                        end
                     end
                     REQ_REVERSE: begin
                        cmd.op = OP_REVERSE;
                     end
                     default: begin
                        cmd.op = OP_NONE;
                     end
                  endcase
               end
            end
         end
         ST_LIST: begin
            if (!status.list_more) begin
               state_in = ST_IDLE;
            end else if (status.rsp_free) begin
               cmd.op = OP_LIST_READ;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   a_no_accept_in_list: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_LIST) |-> !req_ready)
      else $error("request taken while listing");

   a_list_start_enters_list: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == OP_LIST_START) |=> (state_ff == ST_LIST))
      else $error("list start did not enter list state");

   a_read_only_in_list: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == OP_LIST_READ) |-> (state_ff == ST_LIST) && !cmd.status_load)
      else $error("list read outside list state");

endmodule

// ===== rtl/core/bdq_dp.sv =====
// ----------------------------------------------------------------------------
// bdq_dp
// Deque datapath: ring pointers, count, direction flag, entry RAM, list
// read-out pointer and the result output register.
// ----------------------------------------------------------------------------
module bdq_dp
   import bdq_pkg::*;
#(
   parameter int CAPACITY = CAPACITY_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  ctrl_cmd_type              cmd,
   input  logic signed [VALUE_W-1:0] item_value,
   output dp_status_type             status,
   input  logic                      rsp_ready,
   output logic                      rsp_valid,
   output logic signed [VALUE_W-1:0] rsp_out_value,
   output logic [CODE_W-1:0]         rsp_result_kind,
   output logic                      rsp_last_of_run
);

   localparam int IDX_W = $clog2(CAPACITY);
   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int SUM_W = IDX_W + 1;
   localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(CAPACITY - 1);
   localparam logic [SUM_W-1:0] CAP_SUM  = SUM_W'(CAPACITY);
   localparam logic [CNT_W-1:0] CAP_CNT  = CNT_W'(CAPACITY);
   localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

   logic [IDX_W-1:0] front_ff, front_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             reversed_ff, reversed_in;
   logic             created_ff, created_in;
   logic [IDX_W-1:0] ptr_ff, ptr_in;
   logic [CNT_W-1:0] remain_ff, remain_in;
   logic             valid_ff, valid_in;
   kind_type         kind_ff, kind_in;
   logic             last_ff, last_in;

   logic [SUM_W-1:0] tail_sum, back_sum;
   logic [IDX_W-1:0] tail_slot, back_slot, front_dec, front_inc, ptr_next;
   logic             wr_en, rd_en;
   logic [IDX_W-1:0] wr_addr;
   logic [VALUE_W-1:0] rd_data;

   // slot after the last entry and slot of the last entry
   assign tail_sum  = SUM_W'(front_ff) + SUM_W'(count_ff);
   assign tail_slot = (tail_sum >= CAP_SUM) ? IDX_W'(tail_sum - CAP_SUM)
                                            : tail_sum[IDX_W-1:0];
   assign back_sum  = tail_sum - SUM_W'(1);
   assign back_slot = (back_sum >= CAP_SUM) ? IDX_W'(back_sum - CAP_SUM)
                                            : back_sum[IDX_W-1:0];
   assign front_dec = (front_ff == '0) ? IDX_LAST : front_ff - IDX_W'(1);
   assign front_inc = (front_ff == IDX_LAST) ? '0 : front_ff + IDX_W'(1);

   always_comb begin
      if (reversed_ff) begin
         ptr_next = (ptr_ff == '0) ? IDX_LAST : ptr_ff - IDX_W'(1);
      end else begin
         ptr_next = (ptr_ff == IDX_LAST) ? '0 : ptr_ff + IDX_W'(1);
      end
   end

   always_comb begin
      front_in    = front_ff;
      count_in    = count_ff;
      reversed_in = reversed_ff;
      created_in  = created_ff;
      ptr_in      = ptr_ff;
      remain_in   = remain_ff;
      wr_en       = 1'b0;
      wr_addr     = tail_slot;
      rd_en       = 1'b0;
      case (cmd.op)
         OP_CLEAR: begin
            front_in    = '0;
            count_in    = '0;
            reversed_in = 1'b0;
            created_in  = 1'b1;
         end
         OP_PUSH_HIGH: begin
            wr_en    = 1'b1;
            wr_addr  = tail_slot;
            count_in = count_ff + CNT_ONE;
         end
         OP_PUSH_LOW: begin
            wr_en    = 1'b1;
            wr_addr  = front_dec;
            front_in = front_dec;
            count_in = count_ff + CNT_ONE;
         end
         OP_POP: begin
            if (reversed_ff) begin
               front_in = front_inc;
            end
            count_in = count_ff - CNT_ONE;
         end
         OP_REVERSE: begin
            reversed_in = !reversed_ff;
         end
         OP_LIST_START: begin
            ptr_in    = reversed_ff ? back_slot : front_ff;
            remain_in = count_ff;
         end
         OP_LIST_READ: begin
            rd_en     = 1'b1;
            ptr_in    = ptr_next;
            remain_in = remain_ff - CNT_ONE;
         end
         default: begin
            front_in = front_ff;
         end
      endcase
   end

   // result output register
   always_comb begin
      valid_in = valid_ff;
      kind_in  = kind_ff;
      last_in  = last_ff;
      if (cmd.status_load) begin
         valid_in = 1'b1;
         kind_in  = cmd.status_kind;
         last_in  = 1'b1;
      end else if (cmd.op == OP_LIST_READ) begin
         valid_in = 1'b1;
         kind_in  = KIND_ELEM;
         last_in  = (remain_ff == CNT_ONE);
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff    <= '0;
         count_ff    <= '0;
         reversed_ff <= 1'b0;
         created_ff  <= 1'b0;
         remain_ff   <= '0;
         valid_ff    <= 1'b0;
      end else begin
         front_ff    <= front_in;
         count_ff    <= count_in;
         reversed_ff <= reversed_in;
         created_ff  <= created_in;
         remain_ff   <= remain_in;
         valid_ff    <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ptr_ff  <= ptr_in;
      kind_ff <= kind_in;
      last_ff <= last_in;
   end

   bdq_ram #(
      .WIDTH (VALUE_W),
      .DEPTH (CAPACITY)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (item_value),
      .rd_en   (rd_en),
      .rd_addr (ptr_ff),
      .rd_data (rd_data)
   );

   assign status.created   = created_ff;
   assign status.empty     = (count_ff == '0);
   assign status.full      = (count_ff >= CAP_CNT);
   assign status.reversed  = reversed_ff;
   assign status.list_more = (remain_ff != '0);
   assign status.rsp_free  = !valid_ff || rsp_ready;

   assign rsp_valid       = valid_ff;
   assign rsp_result_kind = kind_ff;
   assign rsp_last_of_run = last_ff;
   assign rsp_out_value   = (kind_ff == KIND_ELEM) ? rd_data : '0;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CAP_CNT)
      else $error("entry count above capacity");

   a_remain_bound: assert property (@(posedge clock) disable iff (reset)
      remain_ff <= count_ff)
      else $error("list remainder above entry count");

   a_read_when_free: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == OP_LIST_READ) |-> (!valid_ff || rsp_ready))
      else $error("list read overwrote a pending transaction");

   a_status_is_last: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && (kind_ff != KIND_ELEM)) |-> last_ff)
      else $error("status result not marked last");

endmodule
